@@ rtl/fdre_pkg.sv @@
package fdre_pkg;

  localparam int unsigned FrameBytesDef = 8192;
  localparam int unsigned MaxRunDef     = 255;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned RunW       = 8;
  localparam int unsigned CapW       = 16;
  localparam int unsigned CountW     = 16;
  localparam int unsigned BytesW     = 17;
  localparam int unsigned ChunkBytes = 8;
  localparam int unsigned LaneW      = 3;
  localparam int unsigned WordW      = 64;
  localparam int unsigned ValidW     = 4;
  localparam int unsigned ChunkIdxW  = 6;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned RegIdxW  = 1;

  localparam logic [RegIdxW-1:0] RegOutCapacity = 1'b0;
  localparam logic [CapW-1:0]    CapReset       = 16'hFFFF;
  localparam logic [BytesW-1:0]  BytesReset     = 17'd2;

  localparam logic ReqEncode = 1'b0;
  localparam logic ReqLoad   = 1'b1;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindChunk   = 2'd1,
    KindTrlOk   = 2'd2,
    KindTrlFail = 2'd3
  } kind_e;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] byte_value;
    logic             end_of_frame;
  } req_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [RunW-1:0]   match_count;
    logic [RunW-1:0]   miss_count;
    logic [WordW-1:0]  data_word;
    logic [ValidW-1:0] valid_bytes;
    logic [CountW-1:0] record_count;
    logic [CountW-1:0] total_bytes;
    logic              last_result;
  } rsp_item_t;

  // Work handed from the encoder to the result sequencer.
  typedef struct packed {
    logic            start;
    logic            has_rec;
    logic            eof;
    logic [RunW-1:0] match_count;
    logic [RunW-1:0] miss_count;
  } job_t;

  typedef struct packed {
    logic              fail;
    logic [RunW-1:0]   match_count;
    logic [CountW-1:0] record_count;
    logic [CountW-1:0] total_bytes;
  } trailer_t;

  typedef struct packed {
    logic             we;
    logic [RunW-1:0]  idx;
    logic [ByteW-1:0] byte_value;
  } miss_wr_t;

  typedef struct packed {
    logic busy;
    logic trailer_sent;
  } emit_status_t;

endpackage

@@ rtl/fdre_stream_if.sv @@
interface fdre_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fdre_ram.sv @@
module fdre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fdre_apb_regs.sv @@
module fdre_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdre_pkg::PaddrW-1:0]   paddr,
  input  logic [fdre_pkg::ApbDataW-1:0] pwdata,
  output logic [fdre_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [fdre_pkg::CapW-1:0]     cap_o
);

  logic [fdre_pkg::RegIdxW-1:0] reg_idx;
  logic                         wr_cap;
  logic [fdre_pkg::CapW-1:0]    cap_q;
  logic [fdre_pkg::CapW-1:0]    cap_d;

  assign reg_idx = paddr[fdre_pkg::PaddrW-1:2];
  assign wr_cap  = psel && penable && pwrite && (reg_idx == fdre_pkg::RegOutCapacity);
  assign cap_d   = wr_cap ? pwdata[fdre_pkg::CapW-1:0] : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= fdre_pkg::CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == fdre_pkg::RegOutCapacity) begin
      prdata = fdre_pkg::ApbDataW'(cap_q);
    end
  end

  assign pready = 1'b1;
  assign cap_o  = cap_q;

endmodule

@@ rtl/fdre_emitter.sv @@
module fdre_emitter #(
  parameter int unsigned MAX_RUN = fdre_pkg::MaxRunDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fdre_pkg::job_t         job_i,
  input  fdre_pkg::trailer_t     trl_i,
  input  fdre_pkg::miss_wr_t     miss_wr_i,
  output fdre_pkg::emit_status_t status_o,
  fdre_stream_if.source          rsp_o
);

  localparam int unsigned MissWords = (MAX_RUN + fdre_pkg::ChunkBytes - 1) / fdre_pkg::ChunkBytes;
  localparam int unsigned MissAw    = (MissWords > 1) ? $clog2(MissWords) : 1;
  localparam int unsigned IdxW      = fdre_pkg::ChunkIdxW;
  localparam int unsigned LaneW     = fdre_pkg::LaneW;
  localparam int unsigned ByteW     = fdre_pkg::ByteW;
  localparam int unsigned WordW     = fdre_pkg::WordW;

  localparam logic [1:0] EIdle  = 2'd0;
  localparam logic [1:0] EHdr   = 2'd1;
  localparam logic [1:0] EChunk = 2'd2;
  localparam logic [1:0] ETrl   = 2'd3;

  localparam logic [LaneW-1:0] LaneLast = LaneW'(fdre_pkg::ChunkBytes - 1);

  logic [1:0]                  state_q, state_d;
  logic [fdre_pkg::RunW-1:0]   m_q, m_d, k_q, k_d;
  logic                        eof_q, eof_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [WordW-1:0]            asm_q;
  logic                        out_valid_q, out_valid_d;
  fdre_pkg::rsp_item_t         out_q, out_d;

  logic                        out_free;
  logic                        load;
  logic                        trailer_sent;
  logic [IdxW-1:0]             full_words;
  logic [IdxW-1:0]             nchunks;
  logic [LaneW-1:0]            rem;
  logic                        full;
  logic                        last_chunk;
  logic [WordW-1:0]            tail_word;
  logic [WordW-1:0]            ram_rd;
  logic [LaneW-1:0]            wr_lane;
  logic                        ram_we;

  // Miss bytes gather in a word register; each full word goes to the RAM.
  assign wr_lane = miss_wr_i.idx[LaneW-1:0];
  assign ram_we  = miss_wr_i.we && (wr_lane == LaneLast);

  fdre_ram #(
    .WIDTH(WordW),
    .DEPTH(MissWords)
  ) u_miss_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(miss_wr_i.idx[MissAw+LaneW-1:LaneW]),
    .wdata_i({miss_wr_i.byte_value, asm_q[WordW-ByteW-1:0]}),
    .raddr_i(idx_d[MissAw-1:0]),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i) begin
    if (miss_wr_i.we) begin
      asm_q[{wr_lane, 3'b000} +: ByteW] <= miss_wr_i.byte_value;
    end
  end

  assign full_words = IdxW'(k_q[fdre_pkg::RunW-1:LaneW]);
  assign rem        = k_q[LaneW-1:0];
  assign nchunks    = full_words + IdxW'(|rem);
  assign full       = idx_q < full_words;
  assign last_chunk = (idx_q + IdxW'(1)) == nchunks;
  assign out_free   = !out_valid_q || rsp_o.ready;

  // Zero the lanes past the end of a short final chunk.
  always_comb begin
    for (int l = 0; l < fdre_pkg::ChunkBytes; l++) begin
      tail_word[l*ByteW +: ByteW] = (LaneW'(l) < rem) ? asm_q[l*ByteW +: ByteW] : '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    m_d          = m_q;
    k_d          = k_q;
    eof_d        = eof_q;
    idx_d        = idx_q;
    out_d        = out_q;
    load         = 1'b0;
    trailer_sent = 1'b0;
    unique case (state_q)
      EIdle: begin
        idx_d = '0;
        if (job_i.start) begin
          m_d     = job_i.match_count;
          k_d     = job_i.miss_count;
          eof_d   = job_i.eof;
          state_d = job_i.has_rec ? EHdr : ETrl;
        end
      end
      EHdr: begin
        if (out_free) begin
          load              = 1'b1;
          out_d             = '0;
          out_d.kind        = fdre_pkg::KindHeader;
          out_d.match_count = m_q;
          out_d.miss_count  = k_q;
          out_d.last_result = (k_q == '0) && !eof_q;
          if (k_q != '0) begin
            state_d = EChunk;
          end else begin
            state_d = eof_q ? ETrl : EIdle;
          end
        end
      end
      EChunk: begin
        if (out_free) begin
          load              = 1'b1;
          out_d             = '0;
          out_d.kind        = fdre_pkg::KindChunk;
          out_d.data_word   = full ? ram_rd : tail_word;
          out_d.valid_bytes = full ? fdre_pkg::ValidW'(fdre_pkg::ChunkBytes)
                                   : fdre_pkg::ValidW'(rem);
          out_d.last_result = last_chunk && !eof_q;
          idx_d             = idx_q + IdxW'(1);
          if (last_chunk) begin
            state_d = eof_q ? ETrl : EIdle;
          end
        end
      end
      ETrl: begin
        if (out_free) begin
          load               = 1'b1;
          trailer_sent       = 1'b1;
          out_d              = '0;
          out_d.kind         = trl_i.fail ? fdre_pkg::KindTrlFail : fdre_pkg::KindTrlOk;
          out_d.match_count  = trl_i.match_count;
          out_d.record_count = trl_i.record_count;
          out_d.total_bytes  = trl_i.total_bytes;
          out_d.last_result  = 1'b1;
          state_d            = EIdle;
        end
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EIdle;
      m_q         <= '0;
      k_q         <= '0;
      eof_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_q         <= m_d;
      k_q         <= k_d;
      eof_q       <= eof_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.data            = out_q;
  assign status_o.busy         = (state_q != EIdle);
  assign status_o.trailer_sent = trailer_sent;

endmodule

@@ rtl/frame_delta_run_encoder_unit.sv @@
// Results: an item that closes a record or ends a frame is taken into the emitter's state
//   registers, then the output register; results leave one per cycle while the sink is ready.
// Flow: items without results are accepted back to back; an item with results holds off the
//   input until the emitter has loaded its last result into the single output register.
// Reset: rst_ni is asynchronous, active low; position, run counters and record count clear,
//   byte total goes to 2, out_capacity to 65535; reference and miss stores undefined until written.
module frame_delta_run_encoder_unit #(
  parameter int unsigned FRAME_BYTES = fdre_pkg::FrameBytesDef,
  parameter int unsigned MAX_RUN     = fdre_pkg::MaxRunDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fdre_stream_if.sink                   req_i,
  fdre_stream_if.source                 rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdre_pkg::PaddrW-1:0]   paddr,
  input  logic [fdre_pkg::ApbDataW-1:0] pwdata,
  output logic [fdre_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned PosW   = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RefAw  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned RunW   = fdre_pkg::RunW;
  localparam int unsigned BytesW = fdre_pkg::BytesW;
  localparam int unsigned CountW = fdre_pkg::CountW;
  localparam int unsigned ByteW  = fdre_pkg::ByteW;

  localparam logic [PosW-1:0] PosEnd = PosW'(FRAME_BYTES);
  localparam logic [RunW-1:0] RunMax = RunW'(MAX_RUN);

  // Handshake and item fields.
  logic             accept;
  logic             is_load;
  logic             eof;
  logic [ByteW-1:0] in_byte;
  logic             pos_ok;

  // Encoder state.
  logic [PosW-1:0]   pos_q, pos_d;
  logic              in_miss_q, in_miss_d;
  logic [RunW-1:0]   match_q, match_d;
  logic [RunW-1:0]   miss_q, miss_d;
  logic [CountW-1:0] rec_q, rec_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic              failed_q, failed_d;

  // Reference read with same-cycle write forwarding.
  logic             ref_we;
  logic [ByteW-1:0] ref_rd;
  logic             fwd_q;
  logic [ByteW-1:0] fwd_byte_q;
  logic [ByteW-1:0] ref_byte;
  logic             same_byte;

  logic                   close_now;
  logic [RunW-1:0]        close_k;
  logic [BytesW-1:0]      need;
  logic                   rec_emit;
  logic [RunW-1:0]        miss_inc;
  logic [fdre_pkg::CapW-1:0] cap;

  logic              m_nz;
  logic [BytesW-1:0] grow;
  logic              trl_fail;

  fdre_pkg::job_t         job;
  fdre_pkg::trailer_t     trl;
  fdre_pkg::miss_wr_t     miss_wr;
  fdre_pkg::emit_status_t emit_st;

  assign req_i.ready = !emit_st.busy;
  assign accept      = req_i.valid && req_i.ready;
  assign is_load     = (req_i.data.req_type == fdre_pkg::ReqLoad);
  assign eof         = req_i.data.end_of_frame;
  assign in_byte     = req_i.data.byte_value;
  assign pos_ok      = pos_q < PosEnd;

  fdre_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cap_o  (cap)
  );

  // Position: wrap on end of frame, saturate at the end of the store.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (eof) begin
        pos_d = '0;
      end else if (pos_ok) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Read the reference at the next position so the byte is ready when the item arrives.
  assign ref_we = accept && is_load && pos_ok;

  fdre_ram #(
    .WIDTH(ByteW),
    .DEPTH(FRAME_BYTES)
  ) u_ref_ram (
    .clk_i  (clk_i),
    .we_i   (ref_we),
    .waddr_i(pos_q[RefAw-1:0]),
    .wdata_i(in_byte),
    .raddr_i(pos_d[RefAw-1:0]),
    .rdata_o(ref_rd)
  );

  // A load and a read at the same entry in one cycle: the RAM returns old data, so forward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= ref_we && (pos_q[RefAw-1:0] == pos_d[RefAw-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_byte_q <= in_byte;
  end

  assign ref_byte  = fwd_q ? fwd_byte_q : ref_rd;
  assign same_byte = (in_byte == ref_byte);
  assign miss_inc  = miss_q + RunW'(1);

  // Run tracking and record closing for one encode item, and the frame restart after a trailer.
  always_comb begin
    in_miss_d          = in_miss_q;
    match_d            = match_q;
    miss_d             = miss_q;
    rec_d              = rec_q;
    bytes_d            = bytes_q;
    failed_d           = failed_q;
    close_now          = 1'b0;
    close_k            = '0;
    need               = bytes_q;
    rec_emit           = 1'b0;
    miss_wr            = '0;
    miss_wr.byte_value = in_byte;
    if (emit_st.trailer_sent) begin
      // Trailer leaves: start the next frame afresh.
      in_miss_d = 1'b0;
      match_d   = '0;
      miss_d    = '0;
      rec_d     = '0;
      bytes_d   = fdre_pkg::BytesReset;
      failed_d  = 1'b0;
    end else if (accept && !is_load) begin
      if (!pos_ok) begin
        failed_d = 1'b1;
      end else if (!in_miss_q) begin
        if (same_byte) begin
          if (match_q >= RunMax) begin
            // Full match run: close it, this byte opens the next record.
            close_now = 1'b1;
            match_d   = RunW'(1);
          end else begin
            match_d = match_q + RunW'(1);
          end
        end else begin
          in_miss_d   = 1'b1;
          miss_d      = RunW'(1);
          miss_wr.we  = 1'b1;
          miss_wr.idx = '0;
        end
      end else if (same_byte) begin
        close_now = 1'b1;
        close_k   = miss_q;
        match_d   = RunW'(1);
        miss_d    = '0;
        in_miss_d = 1'b0;
      end else begin
        miss_wr.we  = 1'b1;
        miss_wr.idx = miss_q;
        if (miss_inc >= RunMax) begin
          // Full miss run closes at once.
          close_now = 1'b1;
          close_k   = miss_inc;
          match_d   = '0;
          miss_d    = '0;
          in_miss_d = 1'b0;
        end else begin
          miss_d = miss_inc;
        end
      end
      if (eof && pos_ok && in_miss_d) begin
        // End of frame flushes the open miss run as its record.
        close_now = 1'b1;
        close_k   = miss_d;
        match_d   = '0;
        miss_d    = '0;
        in_miss_d = 1'b0;
      end
      need = bytes_q + BytesW'(2) + BytesW'(close_k);
      if (close_now && !failed_q) begin
        if (need > BytesW'(cap)) begin
          failed_d = 1'b1;
        end else begin
          rec_emit = 1'b1;
          bytes_d  = need;
          rec_d    = rec_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      in_miss_q <= 1'b0;
      match_q   <= '0;
      miss_q    <= '0;
      rec_q     <= '0;
      bytes_q   <= fdre_pkg::BytesReset;
      failed_q  <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      in_miss_q <= in_miss_d;
      match_q   <= match_d;
      miss_q    <= miss_d;
      rec_q     <= rec_d;
      bytes_q   <= bytes_d;
      failed_q  <= failed_d;
    end
  end

  assign job.start       = accept && !is_load && (rec_emit || eof);
  assign job.has_rec     = rec_emit;
  assign job.eof         = eof;
  assign job.match_count = match_q;
  assign job.miss_count  = close_k;

  // Trailer from the settled state: an open match-only record counts two bytes.
  assign m_nz     = (match_q != '0);
  assign grow     = m_nz ? (bytes_q + BytesW'(2)) : bytes_q;
  assign trl_fail = failed_q || (grow > BytesW'(cap));

  assign trl.fail         = trl_fail;
  assign trl.match_count  = trl_fail ? '0 : match_q;
  assign trl.record_count = trl_fail ? rec_q : (rec_q + CountW'(m_nz));
  assign trl.total_bytes  = trl_fail ? bytes_q[CountW-1:0] : grow[CountW-1:0];

  fdre_emitter #(
    .MAX_RUN(MAX_RUN)
  ) u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job),
    .trl_i    (trl),
    .miss_wr_i(miss_wr),
    .status_o (emit_st),
    .rsp_o    (rsp_o)
  );

  // An encode item that ends the frame always holds off the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_load && eof) |=> !req_i.ready)
    else $error("end of frame did not start the trailer");

  // Loads never produce results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> req_i.ready)
    else $error("load item stalled the input");

  // Frame totals restart after the trailer leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.trailer_sent |=> (bytes_q == fdre_pkg::BytesReset) && (rec_q == '0) && !failed_q)
    else $error("frame state not cleared after trailer");

  // Failure clears only with a trailer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(failed_q) |-> $past(emit_st.trailer_sent))
    else $error("failure flag dropped without a trailer");

endmodule
